[sv/gcl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_pkg - shared types for the integer GCD / LCM unit
// Controller states and the command / status groups that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package gcl_pkg;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,    // waiting for an input beat
    S_CHECK,   // head of the Euclid loop
    S_REM,     // shift-subtract steps of a % b
    S_SWAP,    // a <= b, b <= remainder
    S_QUO,     // shift-subtract steps of |a| / gcd
    S_MSTART,  // load the shift-add multiplier
    S_MUL,     // shift-add steps of quotient * |b|
    S_FIN      // load the output register
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture operand magnitudes and op
    logic div_start;  // clear remainder, load dividend, clear step count
    logic div_quo;    // with div_start: |a| / gcd instead of a % b
    logic div_step;   // one restoring divide step
    logic gcd_swap;   // a <= b, b <= remainder
    logic mul_start;  // clear accumulator, load multiplicand, clear count
    logic mul_step;   // one shift-add step
    logic res_load;   // capture the final answer
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic b_zero;     // Euclid loop ends
    logic op_lcm;     // operation of the current item
    logic any_zero;   // either operand magnitude is zero
    logic cnt_last;   // final step of a divide or multiply pass
  } status_t;

endpackage
`default_nettype wire

[sv/gcl_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_datapath - operand registers, shared divider and multiplier
// Holds the Euclid pair, a one-bit-a-step restoring divider used for both
// the remainders and the lcm quotient, and a one-bit-a-step shift-add
// multiplier. Driven entirely by the controller's command group.
// ----------------------------------------------------------------------------
module gcl_datapath #(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire gcl_pkg::cmd_t    cmd,
  output gcl_pkg::status_t      status,
  input  wire logic             in_op,
  input  wire logic [63:0]      in_operand_a,
  input  wire logic [63:0]      in_operand_b,
  output logic [63:0]           out_result
);

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);

  logic [WIDTH-1:0] a_r, b_r, ao_r, bo_r;
  logic [WIDTH-1:0] rem_r, quo_r, acc_r, result_r;
  logic [CW-1:0]    cnt_r;
  logic             op_r, zero_r, quo_sel_r;

  logic [WIDTH-1:0] a_in, b_in, mag_a, mag_b;
  logic [WIDTH-1:0] divisor, rem_sh, res_sel;
  logic [WIDTH:0]   diff;
  logic             take;

  // Operand magnitudes, low WIDTH bits only
  assign a_in  = in_operand_a[WIDTH-1:0];
  assign b_in  = in_operand_b[WIDTH-1:0];
  assign mag_a = a_in[WIDTH-1] ? (~a_in + 1'b1) : a_in;
  assign mag_b = b_in[WIDTH-1] ? (~b_in + 1'b1) : b_in;

  // Restoring divide step: shift in next dividend bit, trial subtract
  assign divisor = quo_sel_r ? a_r : b_r;
  assign rem_sh  = {rem_r[WIDTH-2:0], quo_r[WIDTH-1]};
  assign diff    = {1'b0, rem_sh} - {1'b0, divisor};
  assign take    = ~diff[WIDTH];

  // Final answer select
  always_comb begin
    if (!op_r) begin
      res_sel = a_r;
    end else if (zero_r) begin
      res_sel = '0;
    end else begin
      res_sel = acc_r;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r    <= mag_a;
      b_r    <= mag_b;
      ao_r   <= mag_a;
      bo_r   <= mag_b;
      op_r   <= in_op;
      zero_r <= (mag_a == '0) || (mag_b == '0);
    end
    if (cmd.div_start) begin
      rem_r     <= '0;
      quo_r     <= cmd.div_quo ? ao_r : a_r;
      quo_sel_r <= cmd.div_quo;
    end
    if (cmd.div_step) begin
      rem_r <= take ? diff[WIDTH-1:0] : rem_sh;
      quo_r <= {quo_r[WIDTH-2:0], take};
    end
    if (cmd.gcd_swap) begin
      a_r <= b_r;
      b_r <= rem_r;
    end
    // multiply: quo_r is the multiplier, b_r the multiplicand
    if (cmd.mul_start) begin
      acc_r <= '0;
      b_r   <= bo_r;
    end
    if (cmd.mul_step) begin
      if (quo_r[0]) begin
        acc_r <= acc_r + b_r;
      end
      b_r   <= {b_r[WIDTH-2:0], 1'b0};
      quo_r <= {1'b0, quo_r[WIDTH-1:1]};
    end
    if (cmd.res_load) begin
      result_r <= res_sel;
    end
  end

  // Step counter shared by both passes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_start || cmd.mul_start) begin
      cnt_r <= '0;
    end else if (cmd.div_step || cmd.mul_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign status.b_zero   = (b_r == '0);
  assign status.op_lcm   = op_r;
  assign status.any_zero = zero_r;
  assign status.cnt_last = (cnt_r == CNT_LAST);

  // Signed WIDTH-bit answer, sign-extended to the port
  assign out_result = 64'($signed(result_r));

endmodule
`default_nettype wire

[sv/gcl_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_ctrl - sequencer for the integer GCD / LCM unit
// Steps the Euclid loop, the lcm quotient and the multiply, and owns the
// input stall and output valid of the two channels.
// ----------------------------------------------------------------------------
module gcl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire gcl_pkg::status_t  status,
  output gcl_pkg::cmd_t          cmd
);

  gcl_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  // Output register can take a new beat when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  // State and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gcl_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      gcl_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = gcl_pkg::S_CHECK;
        end
      end
      gcl_pkg::S_CHECK: begin
        if (status.op_lcm && status.any_zero) begin
          state_nxt = gcl_pkg::S_FIN;
        end else if (status.b_zero) begin
          if (status.op_lcm) begin
            cmd.div_start = 1'b1;
            cmd.div_quo   = 1'b1;
            state_nxt     = gcl_pkg::S_QUO;
          end else begin
            state_nxt = gcl_pkg::S_FIN;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = gcl_pkg::S_REM;
        end
      end
      gcl_pkg::S_REM: begin
        cmd.div_step = 1'b1;
        if (status.cnt_last) begin
          state_nxt = gcl_pkg::S_SWAP;
        end
      end
      gcl_pkg::S_SWAP: begin
        cmd.gcd_swap = 1'b1;
        state_nxt    = gcl_pkg::S_CHECK;
      end
      gcl_pkg::S_QUO: begin
        cmd.div_step = 1'b1;
        if (status.cnt_last) begin
          state_nxt = gcl_pkg::S_MSTART;
        end
      end
      gcl_pkg::S_MSTART: begin
        cmd.mul_start = 1'b1;
        state_nxt     = gcl_pkg::S_MUL;
      end
      gcl_pkg::S_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.cnt_last) begin
          state_nxt = gcl_pkg::S_FIN;
        end
      end
      gcl_pkg::S_FIN: begin
        if (out_free) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = gcl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gcl_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  // Checks on the sequencer
  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == gcl_pkg::S_CHECK))
    else $error("accepted beat did not enter the Euclid loop");

  a_rem_to_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gcl_pkg::S_REM && status.cnt_last) |=> (state_r == gcl_pkg::S_SWAP))
    else $error("remainder pass did not end in a swap");

  a_mul_only_lcm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gcl_pkg::S_QUO || state_r == gcl_pkg::S_MUL) |-> status.op_lcm)
    else $error("lcm steps taken for a gcd beat");

  a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gcl_pkg::S_FIN && out_free)
      |=> (out_valid_r && state_r == gcl_pkg::S_IDLE))
    else $error("finished result not presented");

endmodule
`default_nettype wire

[sv/integer_gcd_lcm_unit.sv]
`default_nettype none
// Passes: the one-bit-a-cycle restoring divider makes one pass per Euclid
//   remainder, up to 91 at WIDTH = 64; lcm adds a quotient and a multiply
//   pass. Lcm with a zero operand or gcd with b zero skips every pass.
// Throughput: one item at a time; the next beat is taken once the result
//   is in the output register, while that result still waits.
// Reset: rst_n synchronous, active low; clears the sequencer and out_valid.
// ----------------------------------------------------------------------------
// integer_gcd_lcm_unit - integer GCD / LCM of operand magnitudes
// Euclid's remainder loop gives the gcd; lcm is (|a| / gcd) * |b| modulo
// 2^WIDTH, read back as signed WIDTH-bit and sign-extended.
// ----------------------------------------------------------------------------
module integer_gcd_lcm_unit #(
  parameter int WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [63:0] in_operand_a,
  input  wire logic [63:0] in_operand_b,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_result
);

  gcl_pkg::cmd_t    cmd;
  gcl_pkg::status_t status;

  // Sequencer
  gcl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Operand registers, divider and multiplier
  gcl_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_op        (in_op),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_result   (out_result)
  );

endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the integer GCD / LCM unit
// Drives operand pairs through the valid/stall input channel and checks each
// result beat against a predictor of the gcd / lcm of the operand magnitudes,
// wrapped to WIDTH bits. A directed table covers zeros, extreme values, the
// worst Euclid case and lcm wrap; random pairs follow. Both sides idle at
// random, and the result side once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          W            = 64;
  localparam logic [63:0] WMASK        = {64{1'b1}} >> (64 - W);
  localparam logic [63:0] MIN_S        = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_S        = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] FIB_92       = 64'd7540113804746346429;
  localparam logic [63:0] FIB_91       = 64'd4660046610375530309;
  localparam int          RAND_ITEMS   = 830;
  localparam int          HOLD_AT      = 150;    // result count at the long hold-off
  localparam int          HOLD_CYCLES  = 2500;
  localparam int          QUIET_LIMIT  = 40000;
  localparam int          DRAIN_CYCLES = 200;
  localparam int          N_DIR        = 23;

  typedef enum logic {
    OP_GCD = 1'b0,
    OP_LCM = 1'b1
  } gcl_op_t;

  // One row of the directed table; want is only meaningful when known is set
  typedef struct packed {
    gcl_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
    logic        known;
    logic [63:0] want;
  } dir_row_t;

  // An accepted beat still waiting for its result
  typedef struct {
    int unsigned idx;
    gcl_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] want;
  } pending_t;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{OP_GCD, 64'd0,           64'd0,            1'b1, 64'd0},
    '{OP_LCM, 64'd0,           64'd5,            1'b1, 64'd0},
    '{OP_LCM, -64'd7,          64'd0,            1'b1, 64'd0},
    '{OP_GCD, 64'd0,           -64'd9,           1'b1, 64'd9},
    '{OP_GCD, MIN_S,           64'd0,            1'b1, MIN_S},
    '{OP_GCD, MIN_S,           MIN_S,            1'b1, MIN_S},
    '{OP_LCM, MIN_S,           64'd1,            1'b1, MIN_S},
    '{OP_LCM, -64'd1,          MIN_S,            1'b1, MIN_S},
    '{OP_GCD, MAX_S,           MAX_S,            1'b1, MAX_S},
    '{OP_LCM, MAX_S,           MAX_S,            1'b1, MAX_S},
    '{OP_GCD, -64'd1,          -64'd1,           1'b1, 64'd1},
    '{OP_GCD, 64'd12,          -64'd18,          1'b1, 64'd6},
    '{OP_LCM, -64'd4,          64'd6,            1'b1, 64'd12},
    '{OP_GCD, FIB_92,          -FIB_91,          1'b1, 64'd1},
    '{OP_LCM, FIB_92,          FIB_91,           1'b0, 64'd0},
    '{OP_LCM, MAX_S,           MAX_S - 64'd1,    1'b0, 64'd0},
    '{OP_LCM, MIN_S,           MAX_S,            1'b0, 64'd0},
    '{OP_GCD, MIN_S,           -(64'd1 << 62),   1'b1, 64'd1 << 62},
    '{OP_LCM, 64'h1_0000_0001, 64'hFFFF_FFFF,    1'b0, 64'd0},
    '{OP_LCM, 64'd1,           MAX_S,            1'b1, MAX_S},
    '{OP_GCD, 64'd0,           MIN_S,            1'b1, MIN_S},
    '{OP_LCM, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0},
    '{OP_GCD, 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF, 1'b0, 64'd0}
  };

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic        in_op        = 1'b0;
  logic [63:0] in_operand_a = '0;
  logic [63:0] in_operand_b = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [63:0] out_result;

  pending_t    answers_due [$];
  int unsigned beats_sent   = 0;
  int unsigned gcd_beats    = 0;
  int unsigned lcm_beats    = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count   = 0;

  integer_gcd_lcm_unit #(
    .WIDTH(W)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_result  (out_result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Magnitude of the low W bits, read as two's complement, as unsigned
  function automatic logic [63:0] magnitude_of(logic [63:0] v);
    logic [63:0] m;
    m = v & WMASK;
    if (m[W-1]) m = (~m + 64'd1) & WMASK;
    return m;
  endfunction

  // Expected result beat: Euclid gcd, or (|a| / gcd) * |b| wrapped to W bits
  function automatic logic [63:0] gcd_lcm_of(gcl_op_t op, logic [63:0] a, logic [63:0] b);
    logic [63:0] ma, mb, x, y, r, res;
    ma = magnitude_of(a);
    mb = magnitude_of(b);
    x  = ma;
    y  = mb;
    while (y != 64'd0) begin
      r = x % y;
      x = y;
      y = r;
    end
    if (op == OP_GCD) res = x;
    else if (ma == 64'd0 || mb == 64'd0) res = '0;
    else res = ((ma / x) * mb) & WMASK;
    res &= WMASK;
    if (res[W-1]) res |= ~WMASK;
    return res;
  endfunction

  // Random operand of a random bit length, sign chosen at random
  function automatic logic [63:0] rand_operand(int unsigned lo_w, int unsigned hi_w);
    int unsigned w;
    logic [63:0] v;
    w = $urandom_range(hi_w, lo_w);
    v = {$urandom, $urandom} >> (64 - w);
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // Zero, one, minus one, the signed extremes and powers of two
  function automatic logic [63:0] edge_operand();
    logic [63:0] p;
    p = 64'd1 << $urandom_range(0, 63);
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 64'd1;
      2: return '1;
      3: return MIN_S;
      4: return MAX_S;
      5: return p;
      default: return -p;
    endcase
  endfunction

  // Offer one input beat after a random gap and log its expected answer
  task automatic offer_pair(input gcl_op_t op, input logic [63:0] a, input logic [63:0] b,
                            input logic known, input logic [63:0] want);
    int unsigned gap;
    pending_t    due;
    gap = (((beats_sent / 40) % 5) == 4) ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_op        <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (in_stall);
    due.idx  = beats_sent;
    due.op   = op;
    due.a    = a;
    due.b    = b;
    due.want = known ? want : gcd_lcm_of(op, a, b);
    answers_due.push_back(due);
    beats_sent++;
    if (op == OP_GCD) gcd_beats++;
    else lcm_beats++;
  endtask

  // Reset, directed table, random pairs, drain and verdict
  initial begin : stimulus
    int unsigned pick;
    gcl_op_t     op;
    logic [63:0] a, b, g;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (DIR_ROWS[i])
      offer_pair(DIR_ROWS[i].op, DIR_ROWS[i].a, DIR_ROWS[i].b,
                 DIR_ROWS[i].known, DIR_ROWS[i].want);

    // Mostly short operands so Euclid stays quick; a share at full width
    for (int k = 0; k < RAND_ITEMS; k++) begin
      pick = $urandom_range(0, 99);
      op   = ($urandom_range(0, 1) == 1) ? OP_LCM : OP_GCD;
      if (pick < 45) begin
        a = rand_operand(1, 16);
        b = rand_operand(1, 16);
      end else if (pick < 60) begin
        a = rand_operand(1, 64);
        b = rand_operand(1, 24);
        if ($urandom_range(0, 1) == 1) begin
          g = a;
          a = b;
          b = g;
        end
      end else if (pick < 70) begin
        a = rand_operand(1, 64);
        b = rand_operand(1, 64);
      end else if (pick < 80) begin
        a = edge_operand();
        b = ($urandom_range(0, 1) == 1) ? edge_operand() : rand_operand(1, 64);
      end else if (pick < 92) begin
        // shared factor, so the gcd is a multiple of its magnitude
        g = rand_operand(1, 12);
        a = g * rand_operand(1, 24);
        b = g * rand_operand(1, 24);
      end else begin
        // large lcm that may wrap
        op = OP_LCM;
        g  = rand_operand(1, 12);
        a  = g * rand_operand(20, 40);
        b  = g * rand_operand(20, 40);
      end
      offer_pair(op, a, b, 1'b0, '0);
    end
    @(negedge clk) in_valid <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d gcd and %0d lcm beats (%0d directed), %0d results checked.",
             gcd_beats, lcm_beats, N_DIR, results_seen);
    $display("Output held off once for %0d cycles with the input still offering beats.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: random stall per beat, calm stretches, one long hold-off
  initial begin : result_sink
    int unsigned hold;
    int unsigned taken;
    bit          held;
    taken = 0;
    held  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken == HOLD_AT && !held) begin
        hold = HOLD_CYCLES;
        held = 1'b1;
      end else if (((taken / 48) % 4) == 3) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 9);
      end
      if (hold != 0) begin
        @(negedge clk) out_stall <= 1'b1;
        do @(posedge clk); while (!out_valid);
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Compare each result beat with the oldest outstanding answer
  always @(posedge clk) begin : result_check
    pending_t due;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (answers_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 40)
          $display("%0t: unexpected result beat %h, expected none", $time, out_result);
      end else begin
        due = answers_due.pop_front();
        if (out_result !== due.want) begin
          fail_count++;
          if (fail_count <= 40)
            $display("%0t: beat %0d %s a=%h b=%h expected %h actual %h", $time, due.idx,
                     due.op.name(), due.a, due.b, due.want, out_result);
        end
      end
    end
  end

  // Watchdog: too long without a beat on either channel
  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet == QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

[filelist.f]
sv/gcl_pkg.sv
sv/gcl_datapath.sv
sv/gcl_ctrl.sv
sv/integer_gcd_lcm_unit.sv
bench/tb_top.sv
